### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock, with or without a reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define VAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define VAT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg
// Types, codes, sine table and saturation shared by the vertex transform.
// ----------------------------------------------------------------------------
package vat_pkg;

    localparam int COORD_W      = 32;
    localparam int ACC_W        = 2 * COORD_W;
    localparam int TRIG_FRAC    = 16;
    localparam int TRIG_W       = TRIG_FRAC + 2;
    localparam int TRIG_ONE     = 1 << TRIG_FRAC;
    localparam int ANGLE_W      = 9;
    localparam int TABLE_IDX_W  = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam int QUARTER_TURN = 90;
    localparam int HALF_TURN    = 180;
    localparam int THREE_QUARTER_TURN = 270;
    localparam int FULL_TURN    = 360;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;

    typedef struct packed {
        trig_t sin_val;
        trig_t cos_val;
    } trig_pair_t;

    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_SCALE     = 2'd1;
    localparam logic [1:0] OP_REFLECT   = 2'd2;
    localparam logic [1:0] OP_ROTATE    = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_Z   = 3'd5;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam trig_t TRIG_UNITY = trig_t'(TRIG_ONE);

    // sin(d degrees) * 2^16, d = 0..90
    localparam logic [TRIG_FRAC:0] SINE_TABLE [0:QUARTER_TURN] = '{
            0,  1144,  2287,  3430,  4572,  5712,  6850,  7987,  9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    function automatic coord_t sat_coord(input acc_t v);
        logic [ACC_W-COORD_W:0] upper;
        upper = v[ACC_W-1:COORD_W-1];
        if (upper == '0 || upper == '1)
            return v[COORD_W-1:0];
        else if (v[ACC_W-1])
            return COORD_MIN;
        else
            return COORD_MAX;
    endfunction

endpackage

### rtl/core/vat_trig.sv
// ----------------------------------------------------------------------------
// vat_trig
// Sine and cosine of a whole-degree angle from the quarter-wave table.
// ----------------------------------------------------------------------------
module vat_trig
    import vat_pkg::*;
(
    input  logic [ANGLE_W-1:0] angle,
    output trig_pair_t         trig
);

    localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(QUARTER_TURN);
    localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(HALF_TURN);
    localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(THREE_QUARTER_TURN);
    localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(FULL_TURN);

    logic [ANGLE_W-1:0]   wrapped;
    logic [ANGLE_W-1:0]   sin_sel;
    logic [ANGLE_W-1:0]   cos_sel;
    logic                 sin_neg;
    logic                 cos_neg;
    logic [TRIG_FRAC:0]   sin_mag;
    logic [TRIG_FRAC:0]   cos_mag;

    assign wrapped = (angle >= DEG_360) ? angle - DEG_360 : angle;

    always_comb
    begin
        priority if (wrapped <= DEG_90)
        begin
            sin_sel = wrapped;
            cos_sel = DEG_90 - wrapped;
            sin_neg = 1'b0;
            cos_neg = 1'b0;
        end
        else if (wrapped <= DEG_180)
        begin
            sin_sel = DEG_180 - wrapped;
            cos_sel = wrapped - DEG_90;
            sin_neg = 1'b0;
            cos_neg = 1'b1;
        end
        else if (wrapped <= DEG_270)
        begin
            sin_sel = wrapped - DEG_180;
            cos_sel = DEG_270 - wrapped;
            sin_neg = 1'b1;
            cos_neg = 1'b1;
        end
        else
        begin
            sin_sel = DEG_360 - wrapped;
            cos_sel = wrapped - DEG_270;
            sin_neg = 1'b1;
            cos_neg = 1'b0;
        end
    end

    assign sin_mag = SINE_TABLE[sin_sel[TABLE_IDX_W-1:0]];
    assign cos_mag = SINE_TABLE[cos_sel[TABLE_IDX_W-1:0]];

    assign trig.sin_val = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign trig.cos_val = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

endmodule

### rtl/core/vat_rotate.sv
// ----------------------------------------------------------------------------
// vat_rotate
// Plane rotation of one coordinate pair: (a*c - b*s, a*s + b*c), rounded.
// ----------------------------------------------------------------------------
module vat_rotate
    import vat_pkg::*;
(
    input  coord_t     a,
    input  coord_t     b,
    input  trig_pair_t trig,
    output coord_t     first,
    output coord_t     second
);

    localparam int PROD_W = COORD_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (TRIG_FRAC - 1);

    logic signed [PROD_W-1:0] prod_ac;
    logic signed [PROD_W-1:0] prod_bs;
    logic signed [PROD_W-1:0] prod_as;
    logic signed [PROD_W-1:0] prod_bc;
    logic signed [SUM_W-1:0]  diff_sum;
    logic signed [SUM_W-1:0]  plus_sum;
    logic signed [SUM_W-1:0]  diff_shift;
    logic signed [SUM_W-1:0]  plus_shift;

    assign prod_ac = a * trig.cos_val;
    assign prod_bs = b * trig.sin_val;
    assign prod_as = a * trig.sin_val;
    assign prod_bc = b * trig.cos_val;

    assign diff_sum = SUM_W'(prod_ac) - SUM_W'(prod_bs);
    assign plus_sum = SUM_W'(prod_as) + SUM_W'(prod_bc);

    // round half up
    assign diff_shift = (diff_sum + HALF_LSB) >>> TRIG_FRAC;
    assign plus_shift = (plus_sum + HALF_LSB) >>> TRIG_FRAC;

    assign first  = sat_coord(ACC_W'(diff_shift));
    assign second = sat_coord(ACC_W'(plus_shift));

endmodule

### rtl/core/vertex_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform_unit
// Translate, scale, reflect or rotate one Q16.16 vertex per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries vx_in, vy_in, vz_in, last_in;
//   a request is taken at a rising edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries the transformed vertex and
//   last_out; the receiver drives out_stall.
//   Configuration is a write port (cfg_wr_en, cfg_index, cfg_data); the user
//   must write it only while no request is in flight; the block does not check it.
//   An angle write loads the sine and cosine registers directly from the table.
//   An accepted request is held in the input register, and its result is
//   then loaded into the output register. Throughput: one vertex per cycle
//   unless stalled; input register, one combinational transform, output register.
//   Stall: a held output keeps its data; one more request is still taken
//   into the input register, then in_stall rises until out_stall drops.
//   Reset: both stages empty, operation translate, axis x, angle 0 and all
//   parameters 0.
// ----------------------------------------------------------------------------
module vertex_affine_transform_unit
    import vat_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  coord_t                vx_in,
    input  coord_t                vy_in,
    input  coord_t                vz_in,
    input  logic                  last_in,

    output logic                  out_valid,
    input  logic                  out_stall,
    output coord_t                vx_out,
    output coord_t                vy_out,
    output coord_t                vz_out,
    output logic                  last_out
);

    localparam int LANES  = 3;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam acc_t SCALE_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic [1:0]   op_reg;
    logic [1:0]   axis_reg;
    trig_pair_t   trig_reg;
    coord_t       px_reg;
    coord_t       py_reg;
    coord_t       pz_reg;
    trig_pair_t   cfg_trig;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    coord_t       vx_s1_reg;
    coord_t       vy_s1_reg;
    coord_t       vz_s1_reg;
    logic         last_s1_reg;

    logic         out_valid_reg;
    logic         out_valid_next;
    coord_t       vx_out_reg;
    coord_t       vy_out_reg;
    coord_t       vz_out_reg;
    logic         last_out_reg;

    logic         accept;
    logic         advance;

    coord_t       lane_in       [LANES];
    coord_t       lane_par      [LANES];
    acc_t         scale_prod    [LANES];
    acc_t         scale_shift   [LANES];
    coord_t       translate_res [LANES];
    coord_t       scale_res     [LANES];
    coord_t       reflect_res   [LANES];
    coord_t       result        [LANES];

    coord_t       rot_a;
    coord_t       rot_b;
    coord_t       rot_first;
    coord_t       rot_second;

    // ---------------- configuration ----------------
    vat_trig u_trig
    (
        .angle (cfg_data[ANGLE_W-1:0]),
        .trig  (cfg_trig)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg           <= OP_TRANSLATE;
            axis_reg         <= AXIS_X;
            trig_reg.sin_val <= '0;
            trig_reg.cos_val <= TRIG_UNITY;
            px_reg           <= '0;
            py_reg           <= '0;
            pz_reg           <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OPERATION: op_reg   <= cfg_data[1:0];
                REG_AXIS:      axis_reg <= cfg_data[1:0];
                REG_ANGLE:     trig_reg <= cfg_trig;
                REG_PARAM_X:   px_reg   <= cfg_data;
                REG_PARAM_Y:   py_reg   <= cfg_data;
                REG_PARAM_Z:   pz_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vx_s1_reg   <= vx_in;
            vy_s1_reg   <= vy_in;
            vz_s1_reg   <= vz_in;
            last_s1_reg <= last_in;
        end
        if (advance)
        begin
            vx_out_reg   <= result[LANE_X];
            vy_out_reg   <= result[LANE_Y];
            vz_out_reg   <= result[LANE_Z];
            last_out_reg <= last_s1_reg;
        end
    end

    // ---------------- transform ----------------
    assign lane_in[LANE_X]  = vx_s1_reg;
    assign lane_in[LANE_Y]  = vy_s1_reg;
    assign lane_in[LANE_Z]  = vz_s1_reg;
    assign lane_par[LANE_X] = px_reg;
    assign lane_par[LANE_Y] = py_reg;
    assign lane_par[LANE_Z] = pz_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            scale_prod[i]    = lane_in[i] * lane_par[i];
            scale_shift[i]   = (scale_prod[i] + SCALE_HALF) >>> FRAC_BITS;
            translate_res[i] = sat_coord(ACC_W'(lane_in[i]) + ACC_W'(lane_par[i]));
            scale_res[i]     = sat_coord(scale_shift[i]);
            reflect_res[i]   = sat_coord(-ACC_W'(lane_in[i]));
        end
    end

    // rotation pair: x -> (y,z), y -> (z,x), z -> (x,y)
    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                rot_a = vy_s1_reg;
                rot_b = vz_s1_reg;
            end
            AXIS_Y:
            begin
                rot_a = vz_s1_reg;
                rot_b = vx_s1_reg;
            end
            default:
            begin
                rot_a = vx_s1_reg;
                rot_b = vy_s1_reg;
            end
        endcase
    end

    vat_rotate u_rotate
    (
        .a      (rot_a),
        .b      (rot_b),
        .trig   (trig_reg),
        .first  (rot_first),
        .second (rot_second)
    );

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            result[i] = lane_in[i];
        end
        unique case (op_reg)
            OP_TRANSLATE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    result[i] = translate_res[i];
                end
            end
            OP_SCALE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    result[i] = scale_res[i];
                end
            end
            OP_REFLECT:
            begin
                unique case (axis_reg)
                    AXIS_X:  result[LANE_X] = reflect_res[LANE_X];
                    AXIS_Y:  result[LANE_Y] = reflect_res[LANE_Y];
                    AXIS_Z:  result[LANE_Z] = reflect_res[LANE_Z];
                    default: ;
                endcase
            end
            OP_ROTATE:
            begin
                unique case (axis_reg)
                    AXIS_X:
                    begin
                        result[LANE_Y] = rot_first;
                        result[LANE_Z] = rot_second;
                    end
                    AXIS_Y:
                    begin
                        result[LANE_Z] = rot_first;
                        result[LANE_X] = rot_second;
                    end
                    AXIS_Z:
                    begin
                        result[LANE_X] = rot_first;
                        result[LANE_Y] = rot_second;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign vx_out    = vx_out_reg;
    assign vy_out    = vy_out_reg;
    assign vz_out    = vz_out_reg;
    assign last_out  = last_out_reg;

endmodule

### rtl/core/vat_checker.sv
// ----------------------------------------------------------------------------
// vat_checker
// Port-level assertions for the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vat_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] vx_out,
    input logic [31:0] vy_out,
    input logic [31:0] vz_out,
    input logic        last_out
);

    // empty pipeline after reset
    `VAT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "out_valid set after reset")

    // input only backs up behind a stalled output
    `VAT_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "in_stall without output stall")

    // accepted request raises out_valid when the output is not blocked
    `VAT_ASSERT(a_latency, clk, rst_n, (in_valid && !in_stall) ##1 !(out_valid && out_stall) |=> out_valid, "request lost in pipeline")

    `VAT_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(vx_out) && $stable(vy_out) && $stable(vz_out) && $stable(last_out)), "stalled output changed")

endmodule

bind vertex_affine_transform_unit vat_checker u_vat_checker (.*);
